[rtl/core/ffga_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffga_pkg: shared types for the first-fit gap allocator
// Operation codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffga_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam int LEN_W     = 16;
    localparam int OUT_POS_W = 20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_RESP
    } ffga_state_t;

    typedef struct packed {
        logic accept_load;
        logic start_alloc;
        logic rd_en;
        logic step;
        logic commit;
        logic miss;
        logic emit;
    } ffga_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic hit;
        logic out_free;
    } ffga_sts_t;

endpackage
`default_nettype wire

[rtl/core/first_fit_gap_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_gap_allocator: first-fit allocator over a table of free gaps
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_operation s_position s_size
//   m_      | out       | m_valid m_ready m_found m_placed_position
//
// A load beat is appended to the table as it is taken, if the table has room.
// An allocate beat reads and compares the entries in turn, one memory read and
// one compare per entry on the single read port, until a gap fits or the
// fill count is reached; the result waits until the output register is free.
// Reset clears the fill count, sequencer and m_valid; the table is not reset.
// A new beat is taken while a result waits in the output register; the
// sequencer holds only if a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
module first_fit_gap_allocator #(
    parameter int MAX_GAPS       = 1024,
    parameter int POSITION_WIDTH = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [19:0] s_position,
    input  wire logic [15:0] s_size,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [19:0]      m_placed_position
);
    import ffga_pkg::*;

    ffga_cmd_t cmd;
    ffga_sts_t sts;

    // sequencer
    ffga_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .sts         (sts),
        .cmd         (cmd)
    );

    // table and search datapath
    ffga_dpath #(
        .MAX_GAPS       (MAX_GAPS),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_position        (s_position),
        .s_size            (s_size),
        .cmd               (cmd),
        .sts               (sts),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_placed_position (m_placed_position)
    );

endmodule
`default_nettype wire

[rtl/core/ffga_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffga_ctrl: allocator sequencer
// Takes input beats, walks the gap table one entry at a time and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module ffga_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire ffga_pkg::ffga_sts_t sts,
    output ffga_pkg::ffga_cmd_t     cmd
);
    import ffga_pkg::*;

    ffga_state_t state_reg;
    ffga_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == OP_ALLOC) begin
                        cmd.start_alloc = 1'b1;
                        state_next      = ST_SCAN;
                    end else begin
                        cmd.accept_load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (sts.scan_end) begin
                    cmd.miss   = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.hit) begin
                    cmd.commit = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/ffga_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffga_dpath: gap table and search datapath
// Holds the gap memory, fill count, scan index, request and result registers.
// ----------------------------------------------------------------------------
module ffga_dpath #(
    parameter int MAX_GAPS       = 1024,
    parameter int POSITION_WIDTH = 20
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [19:0]         s_position,
    input  wire logic [15:0]         s_size,
    input  wire ffga_pkg::ffga_cmd_t cmd,
    output ffga_pkg::ffga_sts_t      sts,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_found,
    output logic [19:0]              m_placed_position
);
    import ffga_pkg::*;

    localparam int AW   = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
    localparam int CW   = AW + 1;
    localparam int PW   = POSITION_WIDTH;
    localparam int SW   = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    typedef struct packed {
        logic [PW-1:0]    start;
        logic [LEN_W-1:0] len;
    } gap_t;

    gap_t             mem [MAX_GAPS];
    gap_t             rd_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    idx_reg;
    logic [PW-1:0]    req_pos_reg;
    logic [LEN_W-1:0] req_sz_reg;
    logic             res_found_reg;
    logic [PW-1:0]    res_pos_reg;
    logic             m_valid_reg;
    logic             m_found_reg;
    logic [19:0]      m_pos_reg;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    gap_t             wr_data;
    logic [SW-1:0]    adv_sum;
    logic [PW-1:0]    adv_start;

    // advance the chosen start, saturating at the top position
    always_comb begin
        adv_sum   = SW'(rd_reg.start) + SW'(req_sz_reg);
        adv_start = (adv_sum > SW'(POS_MAX)) ? POS_MAX : PW'(adv_sum);
    end

    // single write port: append on load, shrink on commit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = '{start: adv_start, len: rd_reg.len - req_sz_reg};
        if (cmd.accept_load) begin
            wr_en   = (count_reg < CW'(MAX_GAPS));
            wr_addr = count_reg[AW-1:0];
            wr_data = '{start: PW'(s_position), len: s_size};
        end else if (cmd.commit) begin
            wr_en = 1'b1;
        end
    end

    // gap memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.accept_load && count_reg < CW'(MAX_GAPS)) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // request capture and scan index
    always_ff @(posedge aclk) begin
        if (cmd.start_alloc) begin
            req_pos_reg <= PW'(s_position);
            req_sz_reg  <= s_size;
            idx_reg     <= '0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + CW'(1);
        end
    end

    // result capture
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= rd_reg.start;
        end else if (cmd.miss) begin
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_found_reg <= res_found_reg;
            m_pos_reg   <= 20'(res_pos_reg);
        end
    end

    always_comb begin
        sts.scan_end = (idx_reg >= count_reg);
        sts.hit      = (rd_reg.len >= req_sz_reg) && (rd_reg.start <= req_pos_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = m_found_reg;
    assign m_placed_position = m_pos_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_GAPS))
        else $error("fill count beyond table depth");
    a_commit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> idx_reg < count_reg)
        else $error("commit outside filled entries");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> m_pos_reg == '0)
        else $error("failed beat carries a position");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire
